// ===== design/toc_pkg.sv =====
// Shared types, constants and the arctangent table for the tilt classifier.
// No dependencies.
`default_nettype none
package toc_pkg;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ANGLE_FRAC_DEF    = 8;
  localparam int TAB_LEN           = 24;
  localparam int DW                = 36;   // CORDIC datapath width
  localparam int ZW                = 26;   // Q16 degree accumulator width
  localparam logic [ZW-1:0] DEG90_Q16  = ZW'(90 * 65536);
  localparam logic [ZW-1:0] DEG180_Q16 = ZW'(180 * 65536);

  localparam logic [1:0] REG_VLIM = 2'd0;
  localparam logic [1:0] REG_HLIM = 2'd1;
  localparam logic [1:0] REG_GLIM = 2'd2;

  typedef struct packed {
    logic [7:0]  vlim;
    logic [7:0]  hlim;
    logic [15:0] glim;
  } cfg_t;

  function automatic logic [ZW-1:0] atan_q16(input int i);
    logic [ZW-1:0] t;
    t = '0;
    case (i)
      0: t = ZW'(2949120);  1: t = ZW'(1740967);  2: t = ZW'(919879);
      3: t = ZW'(466945);   4: t = ZW'(234379);   5: t = ZW'(117304);
      6: t = ZW'(58666);    7: t = ZW'(29335);    8: t = ZW'(14668);
      9: t = ZW'(7334);     10: t = ZW'(3667);    11: t = ZW'(1833);
      12: t = ZW'(917);     13: t = ZW'(458);     14: t = ZW'(229);
      15: t = ZW'(115);     16: t = ZW'(57);      17: t = ZW'(29);
      18: t = ZW'(14);      19: t = ZW'(7);       20: t = ZW'(4);
      21: t = ZW'(2);       22: t = ZW'(1);       default: t = '0;
    endcase
    return t;
  endfunction
endpackage
`default_nettype wire

// ===== design/toc_sqrt.sv =====
// Pipelined integer square root, two result bits per stage.
// Depends on toc_pkg. Side data travels along with each item.
`default_nettype none
module toc_sqrt #(
  parameter int SW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [63:0]   radicand,
  input  wire logic [SW-1:0] in_side,
  output logic               out_valid,
  output logic [31:0]        root,
  output logic [SW-1:0]      out_side
);
  import toc_pkg::*;
  localparam int NS = 16;   // two bits per stage, 32 root bits

  logic [NS:0]       vld;
  logic [63:0]       rem  [NS+1];
  logic [31:0]       rt   [NS+1];
  logic [SW-1:0]     side [NS+1];

  assign vld[0]  = in_valid;
  assign rem[0]  = radicand;
  assign rt[0]   = '0;
  assign side[0] = in_side;

  // each stage resolves two root bits (restoring method)
  for (genvar s = 0; s < NS; s++) begin : g_st
    logic [63:0] r_n;
    logic [31:0] q_n;
    always_comb begin
      logic [63:0] trial, rr;
      logic [31:0] q;
      rr = rem[s];
      q  = rt[s];
      for (int k = 0; k < 2; k++) begin
        trial = {q, 2'b01} << (62 - 2 * (2 * s + k));
        if (rr >= trial) begin
          rr = rr - trial;
          q  = {q[30:0], 1'b1};
        end else begin
          q  = {q[30:0], 1'b0};
        end
      end
      r_n = rr;
      q_n = q;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1]  <= r_n;
        rt[s+1]   <= q_n;
        side[s+1] <= side[s];
      end
    end
  end

  assign out_valid = vld[NS];
  assign root      = rt[NS];
  assign out_side  = side[NS];
endmodule
`default_nettype wire

// ===== design/toc_cordic.sv =====
// Pipelined vectoring CORDIC: atan2(yy, xx) in Q16 degrees, one stage per
// iteration. Depends on toc_pkg.
`default_nettype none
module toc_cordic #(
  parameter int STAGES = 16
) (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic signed [toc_pkg::DW-1:0] xx,
  input  wire logic signed [toc_pkg::DW-1:0] yy,
  output logic signed [toc_pkg::ZW-1:0]      angle
);
  import toc_pkg::*;
  localparam int NI = (STAGES < TAB_LEN) ? STAGES : TAB_LEN;

  logic signed [DW-1:0] x [NI+2];
  logic signed [DW-1:0] y [NI+2];
  logic signed [ZW-1:0] z [NI+2];
  logic [1:0]           sp [NI+2];   // 0 normal, 1 fixed result
  logic signed [ZW-1:0] fz [NI+2];

  // pre-stage: special cases and left-half mirroring
  always_ff @(posedge clk) begin
    if (en) begin
      sp[0] <= 2'd0;
      fz[0] <= '0;
      x[0]  <= xx;
      y[0]  <= yy;
      z[0]  <= '0;
      if (yy == 0) begin
        sp[0] <= 2'd1;
        fz[0] <= (xx < 0) ? DEG180_Q16 : '0;
      end else if (xx == 0) begin
        sp[0] <= 2'd1;
        fz[0] <= (yy > 0) ? DEG90_Q16 : -DEG90_Q16;
      end else if (xx < 0) begin
        x[0] <= -xx;
        y[0] <= -yy;
        z[0] <= (yy > 0) ? DEG180_Q16 : -DEG180_Q16;
      end
    end
  end

  for (genvar i = 0; i < NI; i++) begin : g_it
    always_ff @(posedge clk) begin
      if (en) begin
        sp[i+1] <= sp[i];
        fz[i+1] <= fz[i];
        if (y[i] > 0) begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + atan_q16(i);
        end else begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - atan_q16(i);
        end
      end
    end
  end

  assign x[NI+1] = x[NI];
  assign y[NI+1] = y[NI];
  assign z[NI+1] = z[NI];
  assign sp[NI+1] = sp[NI];
  assign fz[NI+1] = fz[NI];
  assign angle = (sp[NI+1] == 2'd1) ? fz[NI+1] : z[NI+1];
endmodule
`default_nettype wire

// ===== design/tilt_orientation_classifier.sv =====
// Top level of the tilt classifier: config registers, square root and
// CORDIC pipelines, rounding and flag stage, output register. Uses toc_pkg.
`default_nettype none
// Tilt orientation classifier. Each transfer on the input channel carries
// one accelerometer triple and two gyro rates; exactly one result transfer
// follows with pitch = atan2(-x, sqrt(y^2+z^2)) and roll = atan2(y, z) in
// degrees with ANGLE_FRAC_BITS fraction bits, plus vertical, horizontal and
// fast-motion flags. Throughput is one item per clock when no result is
// stalled. Each item passes the square/gyro stage, 16 square-root stages,
// the special case/mirror stage, min(CORDIC_STAGES, 24) CORDIC iterations
// and the round/clamp/flags stage into the output register.
// The whole pipeline advances together and freezes while a valid result is
// stalled on the output, so that stall reaches the input the same cycle.
// Limits are written over the APB port: 0 vertical, 1 horizontal, 2 gyro.
module tilt_orientation_classifier #(
  parameter int CORDIC_STAGES   = toc_pkg::CORDIC_STAGES_DEF,
  parameter int ANGLE_FRAC_BITS = toc_pkg::ANGLE_FRAC_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] accel_x,
  input  wire logic signed [15:0] accel_y,
  input  wire logic signed [15:0] accel_z,
  input  wire logic signed [15:0] gyro_x,
  input  wire logic signed [15:0] gyro_y,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      pitch_angle,
  output logic signed [16:0]      roll_angle,
  output logic                    vertical_flag,
  output logic                    horizontal_flag,
  output logic                    fast_pitch_motion,
  output logic                    fast_roll_motion
);
  import toc_pkg::*;

  localparam int NI    = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;
  localparam int CLAT  = NI + 1;
  localparam int SHR   = 16 - ANGLE_FRAC_BITS;
  localparam int SIDEW = 2 + 2 * DW;   // gyro flags, roll operands

  cfg_t cfg;
  logic en;

  // whole pipeline holds while a finished result waits
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;
  assign pready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.vlim <= 8'd60;
      cfg.hlim <= 8'd30;
      cfg.glim <= 16'd300;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_VLIM: cfg.vlim <= pwdata[7:0];
        REG_HLIM: cfg.hlim <= pwdata[7:0];
        REG_GLIM: cfg.glim <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_VLIM: prdata = {24'd0, cfg.vlim};
      REG_HLIM: prdata = {24'd0, cfg.hlim};
      REG_GLIM: prdata = {16'd0, cfg.glim};
      default:  prdata = '0;
    endcase
  end

  // stage 1: squares, gyro compare, operand scaling
  logic               s1_valid;
  logic [31:0]        s1_sq;
  logic signed [15:0] s1_ax;
  logic [SIDEW-1:0]   s1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic [16:0] gxa, gya;
    logic signed [31:0] ay32, az32;
    if (en) begin
      gxa   = gyro_x[15] ? 17'(-$signed({gyro_x[15], gyro_x})) : 17'(gyro_x);
      gya   = gyro_y[15] ? 17'(-$signed({gyro_y[15], gyro_y})) : 17'(gyro_y);
      ay32  = 32'(accel_y);
      az32  = 32'(accel_z);
      // each square is at most 2^30, so the sum fits 32 unsigned bits
      s1_sq <= $unsigned(ay32 * ay32) + $unsigned(az32 * az32);
      s1_ax <= accel_x;
      s1_side <= {gxa > 17'(cfg.glim), gya > 17'(cfg.glim),
                  DW'($signed(accel_y)) <<< 14, DW'($signed(accel_z)) <<< 14};
    end
  end

  // square root, carrying pitch numerator, gyro flags and roll operands
  logic                     q_valid;
  logic [31:0]              q_root;
  logic [SIDEW+15:0]        q_side;

  toc_sqrt #(.SW(SIDEW + 16)) u_sqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s1_valid),
    .radicand({4'd0, s1_sq, 28'd0}),
    .in_side({s1_ax, s1_side}),
    .out_valid(q_valid), .root(q_root), .out_side(q_side)
  );

  logic signed [15:0] q_ax;
  logic               q_fgx, q_fgy;
  logic signed [DW-1:0] q_ry, q_rz, p_y, p_x;
  assign {q_ax, q_fgx, q_fgy, q_ry, q_rz} = q_side;
  assign p_y = -(DW'($signed(q_ax)) <<< 14);
  assign p_x = DW'(q_root);

  logic signed [ZW-1:0] pitch_q16, roll_q16;

  toc_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk(clk), .en(en), .xx(p_x), .yy(p_y), .angle(pitch_q16));
  toc_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk(clk), .en(en), .xx(q_rz), .yy(q_ry), .angle(roll_q16));

  // valid and gyro flags ride alongside the CORDIC stages
  logic [CLAT-1:0] d_valid;
  logic [1:0]      d_fg [CLAT];
  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= '0;
    end else if (en) begin
      d_valid <= {d_valid[CLAT-2:0], q_valid};
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d_fg[0] <= {q_fgx, q_fgy};
      for (int k = 1; k < CLAT; k++) d_fg[k] <= d_fg[k-1];
    end
  end

  // round to nearest (ties away), clamp, then flags
  function automatic logic [ZW-1:0] rnd_mag(input logic signed [ZW-1:0] a);
    logic [ZW-1:0] m;
    m = a[ZW-1] ? ZW'(-a) : ZW'(a);
    if (SHR > 0) return ZW'((m + (ZW'(1) << (SHR - 1))) >> SHR);
    else return ZW'(m << (-SHR));
  endfunction

  logic [ZW-1:0] pm, rm, plim, rlim, vl, hl;
  logic          ps, rs;
  always_comb begin
    plim = ZW'(90) << ANGLE_FRAC_BITS;
    rlim = ZW'(180) << ANGLE_FRAC_BITS;
    vl   = ZW'(cfg.vlim) << ANGLE_FRAC_BITS;
    hl   = ZW'(cfg.hlim) << ANGLE_FRAC_BITS;
    pm   = rnd_mag(pitch_q16);
    rm   = rnd_mag(roll_q16);
    if (pm > plim) pm = plim;
    if (rm > rlim) rm = rlim;
    ps   = pitch_q16[ZW-1];
    rs   = roll_q16[ZW-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_valid[CLAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pitch_angle       <= ps ? 16'(-pm) : 16'(pm);
      roll_angle        <= rs ? 17'(-rm) : 17'(rm);
      vertical_flag     <= (pm > vl) || (rm > vl);
      horizontal_flag   <= (pm < hl) && (rm < hl);
      fast_pitch_motion <= d_fg[CLAT-1][1];
      fast_roll_motion  <= d_fg[CLAT-1][0];
    end
  end
endmodule
`default_nettype wire
